/* rtl/hrr_pkg.sv */
// Package with the shared widths, codes and types of the haptic rumble router.
`timescale 1ns / 1ps
package hrr_pkg;

   // Time stamps wrap modulo 2^TIME_BITS.
   localparam int TIME_BITS = 48;

   // Field widths.
   localparam int TAG_BITS   = 32;
   localparam int LEVEL_BITS = 16;
   localparam int DUR_BITS   = 16;
   localparam int SINK_BITS  = 2;
   localparam int PER_BITS   = 32;

   // Packed stream widths, padded to whole bytes.
   localparam int REQ_FIELD_BITS = TAG_BITS + 2 * LEVEL_BITS + SINK_BITS + TIME_BITS;
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = 1 + 2 * LEVEL_BITS + DUR_BITS;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;

   // Configuration port.
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [CSR_IDX_BITS-1:0] CSR_CTRL_DURATION = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CTRL_REFRESH  = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DEV_REFRESH   = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CTRL_ATTACHED = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DEV_ATTACHED  = 3'd4;

   // Configuration reset values.
   localparam logic [DUR_BITS-1:0] CTRL_DURATION_RESET = 16'd1000;
   localparam logic [PER_BITS-1:0] REFRESH_RESET       = 32'd500000000;

   // Wanted output codes.
   localparam logic [SINK_BITS-1:0] SINK_NONE = 2'd0;
   localparam logic [SINK_BITS-1:0] SINK_CTRL = 2'd1;
   localparam logic [SINK_BITS-1:0] SINK_DEV  = 2'd2;
   localparam logic [SINK_BITS-1:0] SINK_BAD  = 2'd3;

   // Commanded output codes.
   localparam logic TARGET_CTRL = 1'b0;
   localparam logic TARGET_DEV  = 1'b1;

   // Input function codes.
   localparam logic FUNC_UPDATE = 1'b0;
   localparam logic FUNC_STOP   = 1'b1;

   // One haptic command.
   typedef struct packed {
      logic [DUR_BITS-1:0]   duration;
      logic [LEVEL_BITS-1:0] high;
      logic [LEVEL_BITS-1:0] low;
      logic                  target;
   } cmd_type;

endpackage

/* rtl/haptic_rumble_router_core.sv */
// Haptic rumble router: routes rumble strengths to the controller or the device output.
`timescale 1ns / 1ps
// Each request transfer passes through an input register, is evaluated combinationally
// against the latched tag, strengths, active output and last send time, and leaves
// zero, one or two commands in a two-slot output buffer, whose slot a drives the
// result channel. That channel moves one command per cycle while rsp_tready is high;
// a request that causes two commands keeps the next one in the input register until
// slot b has drained. The input register takes a new transfer while results still
// wait at the output. Configuration writes are registered; the user must make them
// while no request is in flight, as the block itself does not enforce this.
module haptic_rumble_router_core (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // tdata, lowest bit up: request_tag, strength_low, strength_high, target_sink,
   // now_time, zero padding
   input  logic [hrr_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // tuser: func
   input  logic                               req_tuser,
   // result channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // tdata, lowest bit up: out_target, out_low, out_high, out_duration_ms, zero padding
   output logic [hrr_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   output logic                               rsp_tlast,
   // configuration port
   input  logic                               csr_we,
   input  logic [hrr_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [hrr_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import hrr_pkg::*;

   // Configuration registers.
   logic [DUR_BITS-1:0] ctrl_duration_ff;
   logic [PER_BITS-1:0] ctrl_refresh_ff;
   logic [PER_BITS-1:0] dev_refresh_ff;
   logic                ctrl_attached_ff;
   logic                dev_attached_ff;

   // Router state.
   logic [TAG_BITS-1:0]   stored_tag_ff,  stored_tag_in;
   logic [LEVEL_BITS-1:0] level_low_ff,   level_low_in;
   logic [LEVEL_BITS-1:0] level_high_ff,  level_high_in;
   logic [SINK_BITS-1:0]  active_ff,      active_in;
   logic [TIME_BITS-1:0]  last_send_ff,   last_send_in;

   // Input register.
   logic                  in_valid_ff;
   logic                  in_func_ff;
   logic [TAG_BITS-1:0]   in_tag_ff;
   logic [LEVEL_BITS-1:0] in_low_ff;
   logic [LEVEL_BITS-1:0] in_high_ff;
   logic [SINK_BITS-1:0]  in_sink_ff;
   logic [TIME_BITS-1:0]  in_now_ff;

   // Output buffer: slot a is presented, slot b follows it.
   logic    a_valid_ff, a_valid_in;
   logic    b_valid_ff, b_valid_in;
   logic    a_last_ff,  a_last_in;
   cmd_type a_cmd_ff,   a_cmd_in;
   cmd_type b_cmd_ff,   b_cmd_in;

   logic req_xfer;
   logic rsp_xfer;
   logic in_consume;

   // Evaluation signals.
   logic [SINK_BITS-1:0]  sink;
   logic                  changed;
   logic [LEVEL_BITS-1:0] new_low;
   logic [LEVEL_BITS-1:0] new_high;
   logic                  levels_zero;
   logic [PER_BITS-1:0]   period;
   logic [TIME_BITS-1:0]  delta;
   logic                  resend;
   logic                  e0_valid, e1_valid;
   cmd_type               e0_cmd,   e1_cmd;
   cmd_type               ctrl_stop, dev_stop;

   // Handshakes: the input register moves on when the output buffer can take all results.
   assign rsp_xfer   = rsp_tvalid && rsp_tready;
   assign in_consume = in_valid_ff && !b_valid_ff && (!a_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || in_consume;
   assign req_xfer   = req_tvalid && req_tready;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_duration_ff <= CTRL_DURATION_RESET;
         ctrl_refresh_ff  <= REFRESH_RESET;
         dev_refresh_ff   <= REFRESH_RESET;
         ctrl_attached_ff <= 1'b1;
         dev_attached_ff  <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CTRL_DURATION: ctrl_duration_ff <= csr_wdata[DUR_BITS-1:0];
            CSR_CTRL_REFRESH:  ctrl_refresh_ff  <= csr_wdata[PER_BITS-1:0];
            CSR_DEV_REFRESH:   dev_refresh_ff   <= csr_wdata[PER_BITS-1:0];
            CSR_CTRL_ATTACHED: ctrl_attached_ff <= csr_wdata[0];
            CSR_DEV_ATTACHED:  dev_attached_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Input register valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_xfer) begin
         in_valid_ff <= 1'b1;
      end else if (in_consume) begin
         in_valid_ff <= 1'b0;
      end
   end

   // Input register payload.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_func_ff <= req_tuser;
         in_tag_ff  <= req_tdata[TAG_BITS-1:0];
         in_low_ff  <= req_tdata[TAG_BITS +: LEVEL_BITS];
         in_high_ff <= req_tdata[TAG_BITS+LEVEL_BITS +: LEVEL_BITS];
         in_sink_ff <= req_tdata[TAG_BITS+2*LEVEL_BITS +: SINK_BITS];
         in_now_ff  <= req_tdata[TAG_BITS+2*LEVEL_BITS+SINK_BITS +: TIME_BITS];
      end
   end

   // Fixed stop commands; a stop carries no duration.
   always_comb begin
      ctrl_stop = '0;
      ctrl_stop.target = TARGET_CTRL;
      dev_stop = '0;
      dev_stop.target = TARGET_DEV;
   end

   // Evaluate the registered request against the state.
   always_comb begin
      sink        = (in_sink_ff == SINK_BAD) ? SINK_NONE : in_sink_ff;
      changed     = (in_tag_ff != stored_tag_ff);
      new_low     = changed ? in_low_ff  : level_low_ff;
      new_high    = changed ? in_high_ff : level_high_ff;
      levels_zero = (new_low == '0) && (new_high == '0);
      period      = (sink == SINK_CTRL) ? ctrl_refresh_ff : dev_refresh_ff;
      delta       = in_now_ff - last_send_ff;
      resend      = changed || (active_ff != sink) || (delta >= TIME_BITS'(period));

      stored_tag_in = stored_tag_ff;
      level_low_in  = level_low_ff;
      level_high_in = level_high_ff;
      active_in     = active_ff;
      last_send_in  = last_send_ff;
      e0_valid      = 1'b0;
      e1_valid      = 1'b0;
      e0_cmd        = ctrl_stop;
      e1_cmd        = dev_stop;

      if (in_func_ff == FUNC_STOP) begin
         // Stop everything; tag and send time are kept.
         level_low_in  = '0;
         level_high_in = '0;
         e0_valid      = ctrl_attached_ff;
         e1_valid      = dev_attached_ff;
         active_in     = SINK_NONE;
      end else begin
         stored_tag_in = in_tag_ff;
         level_low_in  = new_low;
         level_high_in = new_high;
         if (levels_zero) begin
            // A new all-zero request stops both outputs.
            e0_valid  = changed && ctrl_attached_ff;
            e1_valid  = changed && dev_attached_ff;
            active_in = SINK_NONE;
         end else begin
            // Leaving an output first stops it.
            if (active_ff != sink) begin
               if (active_ff == SINK_CTRL) begin
                  e0_cmd   = ctrl_stop;
                  e0_valid = ctrl_attached_ff;
               end else if (active_ff == SINK_DEV) begin
                  e0_cmd   = dev_stop;
                  e0_valid = dev_attached_ff;
               end
               active_in = SINK_NONE;
            end
            // Send to the wanted output when something changed or the period is over.
            if (sink != SINK_NONE && resend) begin
               e1_cmd.low  = new_low;
               e1_cmd.high = new_high;
               if (sink == SINK_CTRL) begin
                  e1_cmd.target   = TARGET_CTRL;
                  e1_cmd.duration = ctrl_duration_ff;
                  e1_valid        = ctrl_attached_ff;
               end else begin
                  e1_cmd.target   = TARGET_DEV;
                  e1_cmd.duration = '0;
                  e1_valid        = dev_attached_ff;
               end
               active_in    = sink;
               last_send_in = in_now_ff;
            end
         end
      end
   end

   // Output buffer next state: load on consume, else shift when slot a leaves.
   always_comb begin
      a_valid_in = a_valid_ff;
      b_valid_in = b_valid_ff;
      a_last_in  = a_last_ff;
      a_cmd_in   = a_cmd_ff;
      b_cmd_in   = b_cmd_ff;
      if (in_consume) begin
         if (e0_valid) begin
            a_valid_in = 1'b1;
            a_cmd_in   = e0_cmd;
            a_last_in  = !e1_valid;
            b_valid_in = e1_valid;
            b_cmd_in   = e1_cmd;
         end else begin
            a_valid_in = e1_valid;
            a_cmd_in   = e1_cmd;
            a_last_in  = 1'b1;
            b_valid_in = 1'b0;
         end
      end else if (rsp_xfer) begin
         a_valid_in = b_valid_ff;
         a_cmd_in   = b_cmd_ff;
         a_last_in  = 1'b1;
         b_valid_in = 1'b0;
      end
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff    <= 1'b0;
         b_valid_ff    <= 1'b0;
         stored_tag_ff <= '0;
         level_low_ff  <= '0;
         level_high_ff <= '0;
         active_ff     <= SINK_NONE;
         last_send_ff  <= '0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         if (in_consume) begin
            stored_tag_ff <= stored_tag_in;
            level_low_ff  <= level_low_in;
            level_high_ff <= level_high_in;
            active_ff     <= active_in;
            last_send_ff  <= last_send_in;
         end
      end
   end

   // Output buffer payload.
   always_ff @(posedge clock) begin
      a_last_ff <= a_last_in;
      a_cmd_ff  <= a_cmd_in;
      b_cmd_ff  <= b_cmd_in;
   end

   // Result channel.
   assign rsp_tvalid = a_valid_ff;
   assign rsp_tlast  = a_last_ff;
   assign rsp_tdata  = RSP_DATA_BITS'({a_cmd_ff.duration, a_cmd_ff.high,
                                       a_cmd_ff.low, a_cmd_ff.target});

`ifndef SYNTH
   // The second slot is only filled behind the first.
   assert property (@(posedge clock) disable iff (reset) b_valid_ff |-> a_valid_ff)
      else $error("second result slot holds data while the first is empty");

   // A command that is not the last of its request has its follower queued.
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_tvalid && !rsp_tlast) |-> b_valid_ff)
      else $error("non-last command without a following command");

   // A stop request clears the latched strengths.
   assert property (@(posedge clock) disable iff (reset)
                    (in_consume && in_func_ff == FUNC_STOP) |=>
                    (level_low_ff == '0 && level_high_ff == '0 && active_ff == SINK_NONE))
      else $error("stop request left strengths or active output set");

   // An update that wants no output leaves no output active.
   assert property (@(posedge clock) disable iff (reset)
                    (in_consume && in_func_ff == FUNC_UPDATE &&
                     (in_sink_ff == SINK_NONE || in_sink_ff == SINK_BAD))
                    |=> (active_ff == SINK_NONE))
      else $error("active output set although no output was wanted");
`endif

endmodule
